@@ hdl/control_frame_composer_assert.svh @@
// Assertion macros used by the checker file of the frame composer.
`ifndef CONTROL_FRAME_COMPOSER_ASSERT_SVH
`define CONTROL_FRAME_COMPOSER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CFC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CFC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/cfc_pkg.sv @@
// ----------------------------------------------------------------------------
// cfc_pkg
// Types, constants and the header byte table of the control frame composer.
// ----------------------------------------------------------------------------
`default_nettype none

package cfc_pkg;

	localparam logic [4:0]  HDR_LEN     = 5'd15;
	localparam logic [15:0] LEN_OFFSET  = 16'h0010;
	localparam logic [7:0]  SYNC_D      = 8'h44;
	localparam logic [7:0]  SYNC_S      = 8'h53;
	localparam logic [7:0]  RSVD_BYTE   = 8'h00;

	// Byte positions within the header
	typedef enum logic [3:0] {
		HDR_SYNC0    = 4'd0,
		HDR_SYNC1    = 4'd1,
		HDR_SYNC2    = 4'd2,
		HDR_SYNC3    = 4'd3,
		HDR_INFO     = 4'd4,
		HDR_LEN_HI   = 4'd5,
		HDR_LEN_LO   = 4'd6,
		HDR_SRC_HI   = 4'd7,
		HDR_SRC_LO   = 4'd8,
		HDR_DST_HI   = 4'd9,
		HDR_DST_LO   = 4'd10,
		HDR_RSVD0    = 4'd11,
		HDR_RSVD1    = 4'd12,
		HDR_RSVD2    = 4'd13,
		HDR_RSVD3    = 4'd14
	} cfc_hdr_pos_t;

	// One byte offered to the output register
	typedef struct packed {
		logic       vld;
		logic [7:0] data;
		logic       fin;
	} cfc_beat_t;

	function automatic logic [7:0] hdr_byte(
		input logic [3:0]  idx,
		input logic [7:0]  info,
		input logic [15:0] flen,
		input logic [15:0] sid,
		input logic [15:0] did
	);
		logic [7:0] b;
		case (idx)
			HDR_SYNC0:  b = SYNC_D;
			HDR_SYNC1:  b = SYNC_S;
			HDR_SYNC2:  b = SYNC_D;
			HDR_SYNC3:  b = SYNC_S;
			HDR_INFO:   b = info;
			HDR_LEN_HI: b = flen[15:8];
			HDR_LEN_LO: b = flen[7:0];
			HDR_SRC_HI: b = sid[15:8];
			HDR_SRC_LO: b = sid[7:0];
			HDR_DST_HI: b = did[15:8];
			HDR_DST_LO: b = did[7:0];
			default:    b = RSVD_BYTE;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

@@ hdl/cfc_sequencer.sv @@
// ----------------------------------------------------------------------------
// cfc_sequencer
// Input item register, result index counter and frame state; picks the
// byte for the current result and keeps the running checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module cfc_sequencer (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire logic             first_item,
	input  wire logic             last_item,
	input  wire logic             has_payload,
	input  wire logic [7:0]       payload_byte,
	input  wire logic [3:0]       message_kind,
	input  wire logic [2:0]       content_kind,
	input  wire logic [1:0]       device_kind,
	input  wire logic [15:0]      source_id,
	input  wire logic [15:0]      dest_id,
	input  wire logic [15:0]      payload_length,
	input  wire logic             out_free,
	output cfc_pkg::cfc_beat_t    beat
);
	import cfc_pkg::*;

	logic        vld_s1;
	logic        first_s1;
	logic        last_s1;
	logic        has_s1;
	logic [7:0]  pbyte_s1;
	logic [7:0]  info_s1;
	logic [15:0] flen_s1;
	logic [15:0] sid_s1;
	logic [15:0] did_s1;

	logic [4:0]  pos_q;
	logic        inside_q;
	logic [7:0]  sum_q;

	logic        open_frame;
	logic        en_pay;
	logic        en_ck;
	logic [4:0]  hdr_cnt;
	logic [4:0]  res_cnt;
	logic [4:0]  post_idx;
	logic        in_hdr;
	logic        is_ck;
	logic [7:0]  sum_base;
	logic [7:0]  byte_val;
	logic        emit;
	logic        done;
	logic        load;

	always_comb begin
		open_frame = first_s1 | inside_q;
		en_pay     = has_s1 & open_frame;
		en_ck      = last_s1 & open_frame;
		hdr_cnt    = first_s1 ? HDR_LEN : 5'd0;
		res_cnt    = hdr_cnt + {4'd0, en_pay} + {4'd0, en_ck};
		post_idx   = pos_q - hdr_cnt;
		in_hdr     = first_s1 && (pos_q < HDR_LEN);
		is_ck      = !in_hdr && !((post_idx == 5'd0) && en_pay);
		// a new frame restarts the sum at its first header byte
		sum_base   = (first_s1 && (pos_q == 5'd0)) ? 8'd0 : sum_q;
		if (in_hdr) begin
			byte_val = hdr_byte(pos_q[3:0], info_s1, flen_s1, sid_s1, did_s1);
		end else if (is_ck) begin
			byte_val = sum_q;
		end else begin
			byte_val = pbyte_s1;
		end
		emit       = vld_s1 && (res_cnt != 5'd0) && out_free;
		done       = vld_s1 && ((res_cnt == 5'd0) ||
			(out_free && (pos_q == res_cnt - 5'd1)));
		item_stall = vld_s1 && !done;
		load       = item_valid && !item_stall;
	end

	assign beat = '{vld: emit, data: byte_val, fin: is_ck};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			pos_q    <= 5'd0;
			inside_q <= 1'b0;
			sum_q    <= 8'd0;
		end else begin
			if (load) begin
				vld_s1 <= 1'b1;
			end else if (done) begin
				vld_s1 <= 1'b0;
			end

			if (load || done) begin
				pos_q <= 5'd0;
			end else if (emit) begin
				pos_q <= pos_q + 5'd1;
			end

			if (done && en_ck) begin
				sum_q <= 8'd0;
			end else if (emit && !is_ck) begin
				sum_q <= sum_base + byte_val;
			end

			if (done) begin
				if (en_ck) begin
					inside_q <= 1'b0;
				end else if (first_s1) begin
					inside_q <= 1'b1;
				end
			end
		end
	end

	// Item payload: no reset needed
	always_ff @(posedge clk) begin
		if (load) begin
			first_s1 <= first_item;
			last_s1  <= last_item;
			has_s1   <= has_payload;
			pbyte_s1 <= payload_byte;
			info_s1  <= {message_kind[3:1], content_kind, device_kind};
			flen_s1  <= payload_length + LEN_OFFSET;
			sid_s1   <= source_id;
			did_s1   <= dest_id;
		end
	end

endmodule

`default_nettype wire

@@ hdl/cfc_out_reg.sv @@
// ----------------------------------------------------------------------------
// cfc_out_reg
// Output register of the composer; holds a byte while the sink stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module cfc_out_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfc_pkg::cfc_beat_t beat,
	output logic                  out_free,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [7:0]            out_byte,
	output logic                  frame_end
);
	import cfc_pkg::*;

	logic       vld_q;
	logic [7:0] data_q;
	logic       fin_q;

	assign out_free  = !vld_q || !out_stall;
	assign out_valid = vld_q;
	assign out_byte  = data_q;
	assign frame_end = fin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (out_free) begin
			vld_q <= beat.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && beat.vld) begin
			data_q <= beat.data;
			fin_q  <= beat.fin;
		end
	end

endmodule

`default_nettype wire

@@ hdl/control_frame_composer.sv @@
// ----------------------------------------------------------------------------
// control_frame_composer
// Builds framed control messages: header, payload bytes, checksum.
// ----------------------------------------------------------------------------
// One input transaction yields up to 17 output bytes, one per cycle while
// out_stall is low: a 15-byte header ("DSDS", info, length, source,
// destination, four reserved zeros) when first_item is set, the payload
// byte when has_payload is set, and the additive checksum with frame_end
// when last_item is set. in_stall holds an item until the single output
// byte register has taken its last output byte, so plain payload items
// stream at one byte per clock while out_stall is low, and a header holds
// in_stall for its item. Each item is first captured in the sequencer's
// item register; its first output byte then goes into the output register
// once that is free. Items outside an open frame are dropped without output.
// ----------------------------------------------------------------------------
`default_nettype none

module control_frame_composer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        first_item,
	input  wire logic        last_item,
	input  wire logic        has_payload,
	input  wire logic [7:0]  payload_byte,
	input  wire logic [3:0]  message_kind,
	input  wire logic [2:0]  content_kind,
	input  wire logic [1:0]  device_kind,
	input  wire logic [15:0] source_id,
	input  wire logic [15:0] dest_id,
	input  wire logic [15:0] payload_length,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             frame_end
);
	import cfc_pkg::*;

	cfc_beat_t beat;
	logic      out_free;

	cfc_sequencer u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (in_valid),
		.item_stall     (in_stall),
		.first_item     (first_item),
		.last_item      (last_item),
		.has_payload    (has_payload),
		.payload_byte   (payload_byte),
		.message_kind   (message_kind),
		.content_kind   (content_kind),
		.device_kind    (device_kind),
		.source_id      (source_id),
		.dest_id        (dest_id),
		.payload_length (payload_length),
		.out_free       (out_free),
		.beat           (beat)
	);

	cfc_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat      (beat),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.frame_end (frame_end)
	);

endmodule

`default_nettype wire

@@ hdl/cfc_checker.sv @@
// ----------------------------------------------------------------------------
// cfc_checker
// Port-level checks of the control frame composer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "control_frame_composer_assert.svh"

module cfc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       first_item,
	input wire logic       last_item,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] out_byte,
	input wire logic       frame_end
);

	// A header transaction keeps the input held on the following cycle
	`CFC_ASSERT_NEXT(a_hdr_holds_input, in_valid && !in_stall && first_item, in_stall, "input taken during header burst")

	// A plain payload transaction moves on unless the output side stalls
	`CFC_ASSERT_NEXT(a_payload_streams, in_valid && !in_stall && !first_item && !last_item, !in_stall || out_stall, "payload item did not pass in one cycle")

	// A stalled output byte holds
	`CFC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(frame_end), "stalled output transaction changed")

endmodule

bind control_frame_composer cfc_checker u_cfc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.first_item (first_item),
	.last_item  (last_item),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.out_byte   (out_byte),
	.frame_end  (frame_end)
);

`default_nettype wire
